>>> hdl/ile_pkg.sv
package ile_pkg;

	localparam int CAPACITY_DEF    = 64;
	localparam int HANDLE_BITS_DEF = 32;

	// field widths on the stream ports
	localparam int CMD_W    = 3;
	localparam int POS_W    = 7;
	localparam int HANDLE_W = 32;
	localparam int STATUS_W = 2;
	localparam int FPOS_W   = 6;
	localparam int COUNT_W  = 7;

	localparam int S_CMD_LSB    = 0;
	localparam int S_POS_LSB    = S_CMD_LSB + CMD_W;
	localparam int S_HANDLE_LSB = S_POS_LSB + POS_W;
	localparam int S_FIELDS_W   = S_HANDLE_LSB + HANDLE_W;
	localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int S_PAD_W      = S_TDATA_W - S_FIELDS_W;

	localparam int M_FIELDS_W = STATUS_W + HANDLE_W + 1 + FPOS_W + COUNT_W + 1;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND,
		CMD_INSERT,
		CMD_GET,
		CMD_SET,
		CMD_REMOVE,
		CMD_POP,
		CMD_FIND,
		CMD_CLEAR
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK,
		STAT_RANGE,
		STAT_FULL
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_SET,
		CELL_DEL
	} cell_op_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_HIT,
		FSM_PICK,
		FSM_DONE
	} fsm_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		cell_op_t         op;
		logic             find_mode;
		logic             at_end;
		logic [POS_W-1:0] pos;
	} cell_ctrl_t;

endpackage

>>> hdl/indexed_list_engine.sv
// channel   dir  handshake                     tdata fields (lsb first)
// s_axis    in   s_axis_tvalid/s_axis_tready   cmd, position, handle
// m_axis    out  m_axis_tvalid/m_axis_tready   status, read_handle, found,
//                                              found_position, count, empty_res
//
// a command passes through accept, cell compare, lowest-match pick and commit
// the cells shift, compare and update in parallel; the cell compare and the pick
// of the first hit are registered, the read-back reduction over all cells is combinational
// reset clears the count and the handshake state; stored handles are not cleared
// the commit step waits while the output register holds an untaken result
module indexed_list_engine #(
	parameter int CAPACITY    = ile_pkg::CAPACITY_DEF,
	parameter int HANDLE_BITS = ile_pkg::HANDLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [ile_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // cmd, position, handle
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// status, read_handle, found, found_position, count, empty_res
	output logic [ile_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;

	ile_pkg::fsm_t                     state_q, state_next;
	ile_pkg::cmd_t                     cmd_q;
	logic [ile_pkg::POS_W-1:0]         pos_q;
	logic [HANDLE_BITS-1:0]            handle_q;
	logic [CNT_W-1:0]                  count_q;

	logic                              out_valid_q;
	ile_pkg::status_t                  status_q;
	logic [ile_pkg::HANDLE_W-1:0]      read_q;
	logic                              found_q;
	logic [ile_pkg::FPOS_W-1:0]        fpos_q;
	logic [ile_pkg::COUNT_W-1:0]       count_out_q;
	logic                              empty_q;

	logic                              accept;
	logic                              commit;
	ile_pkg::status_t                  status_c;
	ile_pkg::cell_op_t                 op_c;
	logic [CNT_W-1:0]                  count_next;
	logic [CMP_W-1:0]                  pos_ext;
	logic [CMP_W-1:0]                  cnt_ext;
	logic                              full;
	logic                              index_cmd;
	ile_pkg::cell_ctrl_t               ctrl;

	logic [HANDLE_BITS-1:0]            cell_data [CAPACITY];
	logic [CAPACITY-1:0]               hit;
	logic [HANDLE_BITS-1:0]            pick_data;
	logic [IDX_W-1:0]                  pick_idx;
	logic                              pick_any;
	logic [CAPACITY-1:0]               pick_onehot;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ile_pkg::FSM_IDLE;
		else
			state_q <= state_next;
	end

	always_comb begin
		state_next    = state_q;
		s_axis_tready = 1'b0;
		commit        = 1'b0;
		unique case (state_q)
			ile_pkg::FSM_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_next = ile_pkg::FSM_HIT;
			end
			ile_pkg::FSM_HIT:  state_next = ile_pkg::FSM_PICK;
			ile_pkg::FSM_PICK: state_next = ile_pkg::FSM_DONE;
			ile_pkg::FSM_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					commit     = 1'b1;
					state_next = ile_pkg::FSM_IDLE;
				end
			end
			default: state_next = ile_pkg::FSM_IDLE;
		endcase
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= ile_pkg::cmd_t'(s_axis_tdata[ile_pkg::S_CMD_LSB +: ile_pkg::CMD_W]);
			pos_q    <= s_axis_tdata[ile_pkg::S_POS_LSB +: ile_pkg::POS_W];
			handle_q <= (HANDLE_BITS)'(s_axis_tdata[ile_pkg::S_HANDLE_LSB +: ile_pkg::HANDLE_W]);
		end
	end

	// status, cell operation and new count
	always_comb begin
		pos_ext    = CMP_W'(pos_q);
		cnt_ext    = CMP_W'(count_q);
		full       = (count_q == CNT_W'(CAPACITY));
		status_c   = ile_pkg::STAT_OK;
		op_c       = ile_pkg::CELL_HOLD;
		count_next = count_q;
		index_cmd  = 1'b0;
		unique case (cmd_q) inside
			ile_pkg::CMD_APPEND, ile_pkg::CMD_INSERT: begin
				if (cmd_q == ile_pkg::CMD_INSERT && pos_ext > cnt_ext)
					status_c = ile_pkg::STAT_RANGE;
				else if (full)
					status_c = ile_pkg::STAT_FULL;
				else begin
					op_c       = ile_pkg::CELL_INS;
					count_next = count_q + CNT_W'(1);
				end
			end
			ile_pkg::CMD_GET, ile_pkg::CMD_SET, ile_pkg::CMD_REMOVE, ile_pkg::CMD_POP: begin
				index_cmd = 1'b1;
				if (pos_ext >= cnt_ext)
					status_c = ile_pkg::STAT_RANGE;
				else if (cmd_q == ile_pkg::CMD_SET)
					op_c = ile_pkg::CELL_SET;
				else if (cmd_q != ile_pkg::CMD_GET) begin
					op_c       = ile_pkg::CELL_DEL;
					count_next = count_q - CNT_W'(1);
				end
			end
			ile_pkg::CMD_CLEAR: count_next = '0;
			default: begin
			end
		endcase
	end

	always_comb begin
		ctrl.op        = commit ? op_c : ile_pkg::CELL_HOLD;
		ctrl.find_mode = (cmd_q == ile_pkg::CMD_FIND);
		ctrl.at_end    = (cmd_q == ile_pkg::CMD_APPEND);
		ctrl.pos       = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (commit)
			count_q <= count_next;
	end

	// row of cells, each one entry
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [HANDLE_BITS-1:0] below;
		logic [HANDLE_BITS-1:0] above;
		if (g == 0) begin : g_first
			assign below = '0;
		end else begin : g_below
			assign below = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign above = '0;
		end else begin : g_above
			assign above = cell_data[g+1];
		end
		ile_cell #(
			.IDX         (g),
			.CNT_W       (CNT_W),
			.HANDLE_BITS (HANDLE_BITS)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.handle     (handle_q),
			.below_data (below),
			.above_data (above),
			.data       (cell_data[g]),
			.hit        (hit[g])
		);
	end

	ile_pick #(
		.CAPACITY    (CAPACITY),
		.HANDLE_BITS (HANDLE_BITS),
		.IDX_W       (IDX_W)
	) u_pick (
		.clk         (clk),
		.hit         (hit),
		.cell_data   (cell_data),
		.pick_data   (pick_data),
		.pick_idx    (pick_idx),
		.pick_any    (pick_any),
		.pick_onehot (pick_onehot)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (commit)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q    <= status_c;
			read_q      <= ((cmd_q == ile_pkg::CMD_GET || cmd_q == ile_pkg::CMD_POP) &&
				status_c == ile_pkg::STAT_OK) ? ile_pkg::HANDLE_W'(pick_data) : '0;
			found_q     <= (cmd_q == ile_pkg::CMD_FIND) && pick_any;
			fpos_q      <= ((cmd_q == ile_pkg::CMD_FIND) && pick_any) ?
				ile_pkg::FPOS_W'(pick_idx) : '0;
			count_out_q <= ile_pkg::COUNT_W'(count_next);
			empty_q     <= (count_next == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(ile_pkg::M_PAD_W){1'b0}}, empty_q, count_out_q, fpos_q, found_q,
		read_q, status_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count beyond capacity");

	a_count_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ile_pkg::FSM_DONE |=> $stable(count_q))
		else $error("count changed outside the commit step");

	a_result_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ile_pkg::FSM_DONE))
		else $error("result appeared without a commit");

	a_pick_single: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ile_pkg::FSM_DONE |-> $onehot0(pick_onehot))
		else $error("pick selected more than one cell");

	a_index_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ile_pkg::FSM_DONE && index_cmd && pos_ext < cnt_ext) |->
		$countones(hit) == 1)
		else $error("indexed command did not hit exactly one cell");

endmodule

>>> hdl/ile_cell.sv
module ile_cell #(
	parameter int IDX         = 0,
	parameter int CNT_W       = 7,
	parameter int HANDLE_BITS = ile_pkg::HANDLE_BITS_DEF
) (
	input  logic                     clk,
	input  ile_pkg::cell_ctrl_t      ctrl,
	input  logic [CNT_W-1:0]         count,
	input  logic [HANDLE_BITS-1:0]   handle,
	input  logic [HANDLE_BITS-1:0]   below_data,
	input  logic [HANDLE_BITS-1:0]   above_data,
	output logic [HANDLE_BITS-1:0]   data,
	output logic                     hit
);

	localparam int CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

	logic [HANDLE_BITS-1:0] data_q;
	logic                   hit_q;
	logic [CMP_W-1:0]       eff_pos;
	logic [CMP_W-1:0]       count_ext;
	logic                   at_pos;
	logic                   past_pos;
	logic                   from_pos;

	always_comb begin
		count_ext = CMP_W'(count);
		// append works as an insert at the current count
		eff_pos   = ctrl.at_end ? count_ext : CMP_W'(ctrl.pos);
		at_pos    = (MY_IDX == eff_pos);
		past_pos  = (MY_IDX > eff_pos);
		from_pos  = (MY_IDX >= eff_pos);
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			ile_pkg::CELL_INS: begin
				if (at_pos)
					data_q <= handle;
				else if (past_pos)
					data_q <= below_data;
			end
			ile_pkg::CELL_SET: begin
				if (at_pos)
					data_q <= handle;
			end
			ile_pkg::CELL_DEL: begin
				if (from_pos)
					data_q <= above_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.find_mode)
			hit_q <= (data_q == handle) && (MY_IDX < count_ext);
		else
			hit_q <= at_pos;
	end

	assign data = data_q;
	assign hit  = hit_q;

endmodule

>>> hdl/ile_pick.sv
module ile_pick #(
	parameter int CAPACITY    = ile_pkg::CAPACITY_DEF,
	parameter int HANDLE_BITS = ile_pkg::HANDLE_BITS_DEF,
	parameter int IDX_W       = $clog2(ile_pkg::CAPACITY_DEF)
) (
	input  logic                   clk,
	input  logic [CAPACITY-1:0]    hit,
	input  logic [HANDLE_BITS-1:0] cell_data [CAPACITY],
	output logic [HANDLE_BITS-1:0] pick_data,
	output logic [IDX_W-1:0]       pick_idx,
	output logic                   pick_any,
	output logic [CAPACITY-1:0]    pick_onehot
);

	logic [CAPACITY-1:0] onehot_s1;

	// keep only the lowest set hit bit
	always_ff @(posedge clk) begin
		onehot_s1 <= hit & (~hit + CAPACITY'(1));
	end

	always_comb begin
		pick_data = '0;
		pick_idx  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (onehot_s1[i]) begin
				pick_data = pick_data | cell_data[i];
				pick_idx  = pick_idx | IDX_W'(i);
			end
		end
		pick_any = |onehot_s1;
	end

	assign pick_onehot = onehot_s1;

endmodule

>>> tb/indexed_list_checker.sv
`timescale 1ns / 100ps
module indexed_list_checker #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [ile_pkg::S_TDATA_W-1:0] s_axis_tdata,  // cmd, position, handle
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// status, read_handle, found, found_position, count, empty_res
	input  logic [ile_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output int                            fail_count,
	output int                            pending,
	output int                            replies_seen,
	output int                            range_errors,
	output int                            full_rejects,
	output int                            find_hits
);

	localparam int R_HANDLE_LSB = ile_pkg::STATUS_W;
	localparam int R_FOUND_LSB  = R_HANDLE_LSB + ile_pkg::HANDLE_W;
	localparam int R_FPOS_LSB   = R_FOUND_LSB + 1;
	localparam int R_COUNT_LSB  = R_FPOS_LSB + ile_pkg::FPOS_W;
	localparam int R_EMPTY_LSB  = R_COUNT_LSB + ile_pkg::COUNT_W;

	typedef struct packed {
		ile_pkg::status_t             status;
		logic [ile_pkg::HANDLE_W-1:0] read_handle;
		logic                         found;
		logic [ile_pkg::FPOS_W-1:0]   found_position;
		logic [ile_pkg::COUNT_W-1:0]  count;
		logic                         empty_res;
	} list_reply_t;

	logic [ile_pkg::HANDLE_W-1:0] stored [CAPACITY];
	int                           stored_len;
	list_reply_t                  expected_replies [$];

	task automatic report_mismatch(input string msg);
		if (fail_count < 50)
			$display("[%0t] MISMATCH %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [ile_pkg::HANDLE_W-1:0] seen,
			input logic [ile_pkg::HANDLE_W-1:0] want);
		if (seen !== want)
			report_mismatch($sformatf("reply %0d %s: got %h, expected %h",
				replies_seen, name, seen, want));
	endtask

	// applies one command to the shadow list and returns the reply it should give
	function automatic list_reply_t apply_list_command(input ile_pkg::cmd_t cmd, input int pos,
			input logic [ile_pkg::HANDLE_W-1:0] h);
		list_reply_t r;
		int          slot;
		r = '0;
		r.status = ile_pkg::STAT_OK;
		case (cmd)
			ile_pkg::CMD_APPEND, ile_pkg::CMD_INSERT: begin
				slot = (cmd == ile_pkg::CMD_APPEND) ? stored_len : pos;
				if (slot > stored_len)
					r.status = ile_pkg::STAT_RANGE;
				else if (stored_len >= CAPACITY)
					r.status = ile_pkg::STAT_FULL;
				else begin
					for (int i = stored_len; i > slot; i--)
						stored[i] = stored[i-1];
					stored[slot] = h;
					stored_len++;
				end
			end
			ile_pkg::CMD_GET, ile_pkg::CMD_SET, ile_pkg::CMD_REMOVE, ile_pkg::CMD_POP: begin
				if (pos >= stored_len)
					r.status = ile_pkg::STAT_RANGE;
				else if (cmd == ile_pkg::CMD_SET)
					stored[pos] = h;
				else begin
					if (cmd != ile_pkg::CMD_REMOVE)
						r.read_handle = stored[pos];
					// pop takes the entry out whatever it holds, zero too
					if (cmd != ile_pkg::CMD_GET) begin
						for (int i = pos; i + 1 < stored_len; i++)
							stored[i] = stored[i+1];
						stored_len--;
					end
				end
			end
			ile_pkg::CMD_FIND: begin
				// scan downwards so the lowest match is the one left
				for (int i = stored_len - 1; i >= 0; i--) begin
					if (stored[i] == h) begin
						r.found = 1'b1;
						r.found_position = ile_pkg::FPOS_W'(i);
					end
				end
			end
			default: begin
				stored_len = 0;
			end
		endcase
		r.count = ile_pkg::COUNT_W'(stored_len);
		r.empty_res = (stored_len == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		list_reply_t want;
		if (!arst_n) begin
			stored_len = 0;
			expected_replies.delete();
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				replies_seen++;
				if (expected_replies.size() == 0) begin
					report_mismatch($sformatf("reply %0d (%h) with no command outstanding",
						replies_seen, m_axis_tdata));
				end else begin
					want = expected_replies.pop_front();
					check_field("status",
						ile_pkg::HANDLE_W'(m_axis_tdata[ile_pkg::STATUS_W-1:0]),
						ile_pkg::HANDLE_W'(want.status));
					check_field("read_handle",
						m_axis_tdata[R_HANDLE_LSB +: ile_pkg::HANDLE_W], want.read_handle);
					check_field("found", ile_pkg::HANDLE_W'(m_axis_tdata[R_FOUND_LSB]),
						ile_pkg::HANDLE_W'(want.found));
					check_field("found_position",
						ile_pkg::HANDLE_W'(m_axis_tdata[R_FPOS_LSB +: ile_pkg::FPOS_W]),
						ile_pkg::HANDLE_W'(want.found_position));
					check_field("count",
						ile_pkg::HANDLE_W'(m_axis_tdata[R_COUNT_LSB +: ile_pkg::COUNT_W]),
						ile_pkg::HANDLE_W'(want.count));
					check_field("empty_res", ile_pkg::HANDLE_W'(m_axis_tdata[R_EMPTY_LSB]),
						ile_pkg::HANDLE_W'(want.empty_res));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = apply_list_command(
					ile_pkg::cmd_t'(s_axis_tdata[ile_pkg::S_CMD_LSB +: ile_pkg::CMD_W]),
					int'(s_axis_tdata[ile_pkg::S_POS_LSB +: ile_pkg::POS_W]),
					s_axis_tdata[ile_pkg::S_HANDLE_LSB +: ile_pkg::HANDLE_W]);
				if (want.status == ile_pkg::STAT_RANGE)
					range_errors++;
				if (want.status == ile_pkg::STAT_FULL)
					full_rejects++;
				if (want.found)
					find_hits++;
				expected_replies.push_back(want);
			end
			pending = expected_replies.size();
		end
	end

endmodule

>>> tb/indexed_list_engine_tb.sv
`timescale 1ns / 100ps
module indexed_list_engine_tb;

	localparam int CAPACITY     = ile_pkg::CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1425;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int POOL_SIZE    = 12;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [ile_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;  // cmd, position, handle
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	// status, read_handle, found, found_position, count, empty_res
	logic [ile_pkg::M_TDATA_W-1:0] m_axis_tdata;

	int fail_count, pending, replies_seen, range_errors, full_rejects, find_hits;
	int cycle_count = 0;
	int commands_sent = 0;
	int fill = 0;
	int peak_fill = 0;
	bit src_calm = 1'b0;
	bit sink_calm = 1'b0;
	logic [ile_pkg::HANDLE_W-1:0] handle_pool [POOL_SIZE];

	initial begin
		forever #10 clk = ~clk;
	end

	indexed_list_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	indexed_list_checker #(
		.CAPACITY (CAPACITY)
	) list_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.replies_seen  (replies_seen),
		.range_errors  (range_errors),
		.full_rejects  (full_rejects),
		.find_hits     (find_hits)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
			$display("Test completed with failures");
			$finish;
		end
	end

	// drives one command and waits for its transfer; fill only steers the stimulus
	task automatic issue(input ile_pkg::cmd_t cmd, input int pos,
			input logic [ile_pkg::HANDLE_W-1:0] h);
		int                            gap;
		logic [ile_pkg::S_TDATA_W-1:0] word;
		if ($urandom_range(0, 31) == 0)
			src_calm = !src_calm;
		gap = src_calm ? 0 : $urandom_range(0, 7);
		word = '0;
		word[ile_pkg::S_CMD_LSB +: ile_pkg::CMD_W] = cmd;
		word[ile_pkg::S_POS_LSB +: ile_pkg::POS_W] = pos[ile_pkg::POS_W-1:0];
		word[ile_pkg::S_HANDLE_LSB +: ile_pkg::HANDLE_W] = h;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		// tready only moves at a rising edge, so look at it mid-cycle
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		commands_sent++;
		case (cmd)
			ile_pkg::CMD_APPEND: if (fill < CAPACITY) fill++;
			ile_pkg::CMD_INSERT: if (pos <= fill && fill < CAPACITY) fill++;
			ile_pkg::CMD_REMOVE, ile_pkg::CMD_POP: if (pos < fill) fill--;
			ile_pkg::CMD_CLEAR: fill = 0;
			default: ;
		endcase
		if (fill > peak_fill)
			peak_fill = fill;
	endtask

	// mostly a legal index, leaning on the two ends, sometimes any 7-bit value
	function automatic int pick_position(input bit for_insert);
		int top_idx;
		top_idx = for_insert ? fill : fill - 1;
		if (top_idx < 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 127);
		case ($urandom_range(0, 4))
			0: return 0;
			1: return top_idx;
			default: return $urandom_range(0, top_idx);
		endcase
	endfunction

	// a small pool of repeated handles makes finds hit and duplicates occur
	function automatic logic [ile_pkg::HANDLE_W-1:0] pick_handle(input int pool_pct);
		if ($urandom_range(0, 99) < pool_pct)
			return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	initial begin : sink
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				sink_calm = !sink_calm;
			gap = sink_calm ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(negedge clk);
			while (!m_axis_tvalid) @(negedge clk);
			@(posedge clk);
		end
	end

	initial begin : stimulus
		int            phase;
		int            phase_left;
		int            r;
		ile_pkg::cmd_t c;
		handle_pool[0] = '0;
		handle_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			handle_pool[i] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every indexed access is out of range
		issue(ile_pkg::CMD_GET, 0, 32'h0000_0000);
		issue(ile_pkg::CMD_POP, 0, 32'h0000_0000);
		issue(ile_pkg::CMD_REMOVE, 0, 32'h0000_0000);
		issue(ile_pkg::CMD_SET, 0, 32'h0000_0001);
		issue(ile_pkg::CMD_INSERT, 1, 32'h0000_0002);
		issue(ile_pkg::CMD_FIND, 0, 32'h0000_0000);
		issue(ile_pkg::CMD_CLEAR, 0, 32'h0000_0000);
		// build zero, 5a.., ff.., a5.. using both ends and the middle
		issue(ile_pkg::CMD_INSERT, 0, 32'h0000_0000);
		issue(ile_pkg::CMD_APPEND, 127, 32'hFFFF_FFFF);
		issue(ile_pkg::CMD_INSERT, 2, 32'hA5A5_A5A5);
		issue(ile_pkg::CMD_INSERT, 1, 32'h5A5A_5A5A);
		issue(ile_pkg::CMD_FIND, 0, 32'hFFFF_FFFF);
		issue(ile_pkg::CMD_FIND, 0, 32'h0000_0000);
		issue(ile_pkg::CMD_FIND, 0, 32'h1234_5678);
		issue(ile_pkg::CMD_GET, 3, 32'h0000_0000);
		issue(ile_pkg::CMD_GET, 4, 32'h0000_0000);
		issue(ile_pkg::CMD_GET, 127, 32'h0000_0000);
		// duplicate zero: find must report the first one
		issue(ile_pkg::CMD_SET, 3, 32'h0000_0000);
		issue(ile_pkg::CMD_FIND, 0, 32'h0000_0000);
		issue(ile_pkg::CMD_REMOVE, 1, 32'h0000_0000);
		// popping a zero handle still removes it
		issue(ile_pkg::CMD_POP, 0, 32'h0000_0000);
		issue(ile_pkg::CMD_POP, 1, 32'h0000_0000);
		issue(ile_pkg::CMD_INSERT, 64, 32'h0000_0003);
		issue(ile_pkg::CMD_CLEAR, 0, 32'h0000_0000);
		issue(ile_pkg::CMD_GET, 0, 32'h0000_0000);

		// alternate growing (to full), shrinking (to empty) and mixed stretches
		phase = 2;
		phase_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase = (phase + 1) % 3;
				phase_left = $urandom_range(60, 140);
			end
			phase_left--;
			r = $urandom_range(0, 99);
			case (phase)
				0: begin
					if (r < 35) c = ile_pkg::CMD_APPEND;
					else if (r < 65) c = ile_pkg::CMD_INSERT;
					else if (r < 75) c = ile_pkg::CMD_GET;
					else if (r < 83) c = ile_pkg::CMD_SET;
					else if (r < 93) c = ile_pkg::CMD_FIND;
					else if (r < 96) c = ile_pkg::CMD_REMOVE;
					else c = ile_pkg::CMD_POP;
				end
				1: begin
					if (r < 30) c = ile_pkg::CMD_POP;
					else if (r < 60) c = ile_pkg::CMD_REMOVE;
					else if (r < 70) c = ile_pkg::CMD_GET;
					else if (r < 76) c = ile_pkg::CMD_SET;
					else if (r < 86) c = ile_pkg::CMD_FIND;
					else if (r < 92) c = ile_pkg::CMD_APPEND;
					else c = ile_pkg::CMD_INSERT;
				end
				default: begin
					if (r < 3) c = ile_pkg::CMD_CLEAR;
					else c = ile_pkg::cmd_t'($urandom_range(0, 6));
				end
			endcase
			issue(c, pick_position(c == ile_pkg::CMD_INSERT),
				pick_handle(c == ile_pkg::CMD_FIND ? 70 : 40));
		end
		s_axis_tvalid <= 1'b0;

		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (12) @(posedge clk);
		$display("%0d commands sent, %0d replies checked, list depth peaked at %0d of %0d",
			commands_sent, replies_seen, peak_fill, CAPACITY);
		$display("index errors %0d, full-list rejects %0d, find hits %0d",
			range_errors, full_rejects, find_hits);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
hdl/ile_pkg.sv
hdl/ile_cell.sv
hdl/ile_pick.sv
hdl/indexed_list_engine.sv
tb/indexed_list_checker.sv
tb/indexed_list_engine_tb.sv
